FILE: rtl/core/bgcc_pkg.sv
// shared types, constants and codes for the bipartite graph cycle checker
package bgcc_pkg;

	localparam int MAX_VERTICES_DEF = 32;
	localparam int LENGTH_BITS_DEF  = 16;

	localparam int FUNC_W   = 2;
	localparam int IDX_W    = 5;
	localparam int LEN_W    = 16;
	localparam int STATUS_W = 3;
	localparam int EDGES_W  = 11;
	localparam int VERTS_W  = 6;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_DELETE = 2'd2,
		FUNC_CHECK  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_RANGE     = 3'd1,
		ST_SAME_SIDE = 3'd2,
		ST_EXISTS    = 3'd3,
		ST_NO_EDGE   = 3'd4,
		ST_FULL      = 3'd5,
		ST_ZERO_LEN  = 3'd6
	} status_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              vertex_side;
		logic [IDX_W-1:0]  from_index;
		logic [IDX_W-1:0]  to_index;
		logic [LEN_W-1:0]  edge_length;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    new_vertex_index;
		logic                acyclic;
		logic [EDGES_W-1:0]  total_edges;
		logic [VERTS_W-1:0]  total_vertices;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_EDGE_RD,
		S_EDGE_WAIT,
		S_EDGE_WR,
		S_INIT_RD,
		S_INIT_WAIT,
		S_POP,
		S_POP_WAIT,
		S_SCAN,
		S_FINISH,
		S_RESP
	} state_t;

endpackage

FILE: rtl/core/bgcc_edge_mem.sv
// edge length matrix, one read and one write port, registered read
module bgcc_edge_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

FILE: rtl/core/bgcc_vertex_mem.sv
// per-vertex tables: side, degrees, remaining in-degree and ready queue
module bgcc_vertex_mem #(
	parameter int NV = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [$clog2(NV)-1:0]   a_idx,
	input  logic [$clog2(NV)-1:0]   b_idx,
	output logic                    a_side,
	output logic                    b_side,
	input  logic                    add_en,
	input  logic [$clog2(NV)-1:0]   add_idx,
	input  logic                    add_side,
	input  logic                    ins_en,
	input  logic                    del_en,
	input  logic [$clog2(NV)-1:0]   rem_idx,
	output logic [$clog2(NV+1)-1:0] rem_rd,
	output logic [$clog2(NV+1)-1:0] rem_in_deg,
	input  logic                    rem_wr_en,
	input  logic [$clog2(NV+1)-1:0] rem_wr,
	input  logic [$clog2(NV)-1:0]   q_rd_idx,
	output logic [$clog2(NV)-1:0]   q_rd,
	input  logic                    q_wr_en,
	input  logic [$clog2(NV)-1:0]   q_wr_idx,
	input  logic [$clog2(NV)-1:0]   q_wr
);
	localparam int IW = $clog2(NV);
	localparam int DW = $clog2(NV + 1);

	logic          side_q [NV];
	logic [DW-1:0] in_q   [NV];
	logic [DW-1:0] out_q  [NV];
	logic [DW-1:0] rem_q  [NV];
	logic [IW-1:0] queue_q[NV];
	logic [DW-1:0] a_out_deg;
	logic [DW-1:0] b_in_deg;

	assign a_side     = side_q[a_idx];
	assign b_side     = side_q[b_idx];
	assign b_in_deg   = in_q[b_idx];
	assign a_out_deg  = out_q[a_idx];
	assign rem_rd     = rem_q[rem_idx];
	assign rem_in_deg = in_q[rem_idx];
	assign q_rd       = queue_q[q_rd_idx];

	always_ff @(posedge clk) begin
		if (add_en) begin
			side_q[add_idx] <= add_side;
		end
		if (rem_wr_en) begin
			rem_q[rem_idx] <= rem_wr;
		end
		if (q_wr_en) begin
			queue_q[q_wr_idx] <= q_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NV; i++) begin
				in_q[i]  <= '0;
				out_q[i] <= '0;
			end
		end else begin
			if (add_en) begin
				in_q[add_idx]  <= '0;
				out_q[add_idx] <= '0;
			end
			if (ins_en) begin
				out_q[a_idx] <= a_out_deg + DW'(1);
				in_q[b_idx]  <= b_in_deg + DW'(1);
			end
			if (del_en) begin
				if (a_out_deg != '0) out_q[a_idx] <= a_out_deg - DW'(1);
				if (b_in_deg != '0) in_q[b_idx] <= b_in_deg - DW'(1);
			end
		end
	end
endmodule

FILE: rtl/core/bipartite_graph_cycle_check.sv
// Directed bipartite graph store with edge add/delete and a Kahn cycle check.
// After reset the edge matrix is cleared one entry a cycle with in_ready low.
// Add vertex goes straight to its result step; insert and delete step through
// matrix read, wait, write back and result. The check runs through the
// single-port matrix read: queue setup over the added vertices, then for each
// removed vertex a scan of its matrix row, and a finish step at the end.
// The result sits in an output register; the next item may start while it
// waits, and its last step holds until that register is free.
module bipartite_graph_cycle_check #(
	parameter int MAX_VERTICES = bgcc_pkg::MAX_VERTICES_DEF,
	parameter int LENGTH_BITS  = bgcc_pkg::LENGTH_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bgcc_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output bgcc_pkg::rsp_t  out_data
);
	import bgcc_pkg::*;

	localparam int NV = MAX_VERTICES;
	localparam int IW = $clog2(NV);
	localparam int DW = $clog2(NV + 1);
	localparam int AW = 2 * IW;
	localparam int DEPTH = 1 << AW;

	state_t state_q, state_n;
	req_t   req_q;
	logic [DW-1:0]      vcnt_q;
	logic [EDGES_W-1:0] ecnt_q;
	logic [AW:0]        clr_q;
	logic [DW-1:0]      i_q;
	logic [DW-1:0]      head_q, tail_q, done_q;
	logic [IW-1:0]      v_q;
	logic               scan_vld_q;
	logic [IW-1:0]      scan_j_q;
	rsp_t               rsp_q;
	logic               ov_q;

	logic               rd_en, wr_en;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [LENGTH_BITS-1:0] rd_data, wr_data;

	logic               a_side, b_side;
	logic               add_en, ins_en, del_en;
	logic [IW-1:0]      rem_idx, q_rd_idx, q_wr_idx, q_wr;
	logic [DW-1:0]      rem_rd, rem_wr, rem_in_deg;
	logic               rem_wr_en, q_wr_en;
	logic [IW-1:0]      q_rd;
	logic [IW-1:0]      from_i, to_i;
	logic               range_bad;
	logic [LENGTH_BITS-1:0] len_m;
	logic               set_rsp;
	logic               rsp_free;
	status_t            st_n;
	logic [DW-1:0]      scan_cnt;

	assign from_i = IW'(req_q.from_index);
	assign to_i   = IW'(req_q.to_index);
	assign len_m  = LENGTH_BITS'(req_q.edge_length);
	assign range_bad = (DW'(req_q.from_index) >= vcnt_q) || (DW'(req_q.to_index) >= vcnt_q)
		|| (32'(req_q.from_index) >= NV) || (32'(req_q.to_index) >= NV);

	bgcc_edge_mem #(.DEPTH(DEPTH), .WIDTH(LENGTH_BITS)) u_edge (
		.clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
	);

	bgcc_vertex_mem #(.NV(NV)) u_vert (
		.clk(clk), .arst_n(arst_n), .a_idx(from_i), .b_idx(to_i),
		.a_side(a_side), .b_side(b_side), .add_en(add_en), .add_idx(vcnt_q[IW-1:0]),
		.add_side(req_q.vertex_side), .ins_en(ins_en), .del_en(del_en),
		.rem_idx(rem_idx), .rem_rd(rem_rd), .rem_in_deg(rem_in_deg),
		.rem_wr_en(rem_wr_en), .rem_wr(rem_wr),
		.q_rd_idx(q_rd_idx), .q_rd(q_rd), .q_wr_en(q_wr_en), .q_wr_idx(q_wr_idx),
		.q_wr(q_wr)
	);

	logic [DW-1:0] init_deg;
	logic [IW-1:0] init_sel;
	assign init_sel = i_q[IW-1:0];

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign out_data  = rsp_q;
	assign rsp_free  = !ov_q || out_ready;
	assign scan_cnt  = DW'(scan_j_q) + DW'(1);

	always_comb begin
		state_n   = state_q;
		rd_en     = 1'b0;
		rd_addr   = {from_i, to_i};
		wr_en     = 1'b0;
		wr_addr   = {from_i, to_i};
		wr_data   = '0;
		add_en    = 1'b0;
		ins_en    = 1'b0;
		del_en    = 1'b0;
		rem_idx   = init_sel;
		rem_wr_en = 1'b0;
		rem_wr    = '0;
		q_rd_idx  = head_q[IW-1:0];
		q_wr_en   = 1'b0;
		q_wr_idx  = tail_q[IW-1:0];
		q_wr      = init_sel;
		set_rsp   = 1'b0;
		st_n      = ST_OK;
		init_deg  = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q[AW-1:0];
				if (clr_q == (AW+1)'(DEPTH - 1)) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					case (func_t'(in_data.func))
						FUNC_ADD:    state_n = S_RESP;
						FUNC_CHECK:  state_n = S_INIT_RD;
						default:     state_n = S_EDGE_RD;
					endcase
				end
			end
			S_RESP: begin
				if (rsp_free) begin
					set_rsp = 1'b1;
					if (vcnt_q >= DW'(NV)) begin
						st_n = ST_FULL;
					end else begin
						add_en = 1'b1;
					end
					state_n = S_IDLE;
				end
			end
			S_EDGE_RD: begin
				rd_en   = 1'b1;
				state_n = S_EDGE_WAIT;
			end
			S_EDGE_WAIT: state_n = S_EDGE_WR;
			S_EDGE_WR: begin
				if (rsp_free) begin
					set_rsp = 1'b1;
					state_n = S_IDLE;
					if (range_bad) begin
						st_n = ST_RANGE;
					end else if (func_t'(req_q.func) == FUNC_INSERT) begin
						if (a_side == b_side) st_n = ST_SAME_SIDE;
						else if (rd_data != '0) st_n = ST_EXISTS;
						else if (len_m == '0) st_n = ST_ZERO_LEN;
						else begin
							wr_en   = 1'b1;
							wr_data = len_m;
							ins_en  = 1'b1;
						end
					end else begin
						if (rd_data == '0) st_n = ST_NO_EDGE;
						else begin
							wr_en  = 1'b1;
							del_en = 1'b1;
						end
					end
				end
			end
			S_INIT_RD: begin
				if (i_q >= vcnt_q) begin
					state_n = S_POP;
				end else begin
					rem_wr_en = 1'b1;
					init_deg  = rem_in_deg;
					rem_wr    = init_deg;
					if (init_deg == '0 && tail_q < DW'(NV)) q_wr_en = 1'b1;
				end
			end
			S_POP: begin
				if (head_q >= tail_q) state_n = S_FINISH;
				else state_n = S_SCAN;
			end
			S_SCAN: begin
				rd_en   = (DW'(scan_j_q) < vcnt_q) && !(scan_vld_q && scan_cnt >= vcnt_q);
				rd_addr = {v_q, scan_vld_q ? IW'(scan_cnt) : scan_j_q};
				if (scan_vld_q) begin
					rem_idx = scan_j_q;
					if (rd_data != '0 && rem_rd != '0) begin
						rem_wr_en = 1'b1;
						rem_wr    = rem_rd - DW'(1);
						q_wr      = scan_j_q;
						if (rem_rd == DW'(1) && tail_q < DW'(NV)) q_wr_en = 1'b1;
					end
					if (scan_cnt >= vcnt_q) state_n = S_POP;
				end else if (vcnt_q == '0) begin
					state_n = S_POP;
				end
			end
			S_FINISH: begin
				if (rsp_free) begin
					set_rsp = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			vcnt_q  <= '0;
			ecnt_q  <= '0;
			ov_q    <= 1'b0;
			i_q     <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			done_q  <= '0;
			scan_vld_q <= 1'b0;
			scan_j_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == S_CLEAR) clr_q <= clr_q + (AW+1)'(1);
			if (set_rsp) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (add_en) vcnt_q <= vcnt_q + DW'(1);
			if (ins_en) ecnt_q <= ecnt_q + EDGES_W'(1);
			if (del_en && ecnt_q != '0) ecnt_q <= ecnt_q - EDGES_W'(1);
			if (state_q == S_IDLE) begin
				i_q    <= '0;
				head_q <= '0;
				tail_q <= '0;
				done_q <= '0;
			end
			if (state_q == S_INIT_RD && i_q < vcnt_q) i_q <= i_q + DW'(1);
			if (q_wr_en) tail_q <= tail_q + DW'(1);
			if (state_q == S_POP && head_q < tail_q) begin
				v_q        <= q_rd;
				head_q     <= head_q + DW'(1);
				done_q     <= done_q + DW'(1);
				scan_vld_q <= 1'b0;
				scan_j_q   <= '0;
			end
			if (state_q == S_SCAN) begin
				if (scan_vld_q) scan_j_q <= IW'(scan_cnt);
				scan_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) req_q <= in_data;
		if (set_rsp) begin
			rsp_q.status           <= st_n;
			rsp_q.new_vertex_index <= (state_q == S_RESP && add_en) ? IDX_W'(vcnt_q) : '0;
			rsp_q.acyclic          <= (state_q == S_FINISH) && (done_q == vcnt_q);
			rsp_q.total_edges      <= ins_en ? ecnt_q + EDGES_W'(1)
				: (del_en && ecnt_q != '0) ? ecnt_q - EDGES_W'(1) : ecnt_q;
			rsp_q.total_vertices   <= VERTS_W'(add_en ? vcnt_q + DW'(1) : vcnt_q);
		end
	end
endmodule

FILE: rtl/core/bgcc_checker.sv
// port-level checks for the graph cycle checker, bound to the top level
module bgcc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input bgcc_pkg::req_t   in_data,
	input logic             out_valid,
	input logic             out_ready,
	input bgcc_pkg::rsp_t   out_data
);
	import bgcc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer taken while busy");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_ZERO_LEN)
		else $error("bad status code");

	a_acyc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.acyclic |-> out_data.status == ST_OK)
		else $error("acyclic with error status");
endmodule

bind bipartite_graph_cycle_check bgcc_checker u_bgcc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
	.out_data(out_data)
);

FILE: sim/testbench.sv
// testbench for the bipartite graph cycle checker: directed table plus random graph traffic
`timescale 1ns / 1ps

module testbench;
	import bgcc_pkg::*;

	localparam int NV = 32;
	localparam int RANDOM_ITEMS = 520;
	localparam int QUIET_ITEMS = 60;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		req_t req;
		logic has_rsp;
		rsp_t rsp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	bipartite_graph_cycle_check u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #1 clk = ~clk;

	// graph model
	logic [15:0] lengths [NV][NV];
	logic        sides [NV];
	int          indeg [NV];
	int          outdeg [NV];
	int          nverts;
	int          nedges;

	rsp_t pending_rsp [$];
	bit   pending_chk [$];
	rsp_t last_pred;
	int   errors = 0;
	int   checked = 0;
	int   acyc_seen = 0;
	int   cyc_seen = 0;
	int   idle_cycles = 0;
	bit   quiet = 0;
	bit   timed_out = 0;

	function automatic bit kahn_acyclic();
		int rem [NV];
		int q [$];
		int done;
		int v;
		done = 0;
		for (int i = 0; i < nverts; i++) begin
			rem[i] = indeg[i];
			if (rem[i] == 0)
				q.push_back(i);
		end
		while (q.size() > 0) begin
			v = q.pop_front();
			done++;
			for (int j = 0; j < nverts; j++) begin
				if (lengths[v][j] != 0 && rem[j] != 0) begin
					rem[j]--;
					if (rem[j] == 0)
						q.push_back(j);
				end
			end
		end
		return done == nverts;
	endfunction

	function automatic rsp_t apply_op(req_t r);
		rsp_t o;
		int f;
		int t;
		o = '0;
		f = r.from_index;
		t = r.to_index;
		case (func_t'(r.func))
			FUNC_ADD: begin
				if (nverts >= NV) begin
					o.status = ST_FULL;
				end else begin
					o.new_vertex_index = IDX_W'(nverts);
					sides[nverts] = r.vertex_side;
					indeg[nverts] = 0;
					outdeg[nverts] = 0;
					nverts++;
				end
			end
			FUNC_CHECK: begin
				o.acyclic = kahn_acyclic();
			end
			default: begin
				if (f >= nverts || t >= nverts) begin
					o.status = ST_RANGE;
				end else if (r.func == FUNC_INSERT) begin
					if (sides[f] == sides[t])
						o.status = ST_SAME_SIDE;
					else if (lengths[f][t] != 0)
						o.status = ST_EXISTS;
					else if (r.edge_length == 0)
						o.status = ST_ZERO_LEN;
					else begin
						lengths[f][t] = r.edge_length;
						outdeg[f]++;
						indeg[t]++;
						nedges++;
					end
				end else begin
					if (lengths[f][t] == 0)
						o.status = ST_NO_EDGE;
					else begin
						lengths[f][t] = 0;
						if (outdeg[f] != 0) outdeg[f]--;
						if (indeg[t] != 0) indeg[t]--;
						if (nedges != 0) nedges--;
					end
				end
			end
		endcase
		o.total_edges = EDGES_W'(nedges);
		o.total_vertices = VERTS_W'(nverts);
		return o;
	endfunction

	function automatic req_t make_req(func_t fn, int sd, int f, int t, int len);
		req_t r;
		r.func = fn;
		r.vertex_side = 1'(sd);
		r.from_index = IDX_W'(f);
		r.to_index = IDX_W'(t);
		r.edge_length = LEN_W'(len);
		return r;
	endfunction

	// pick mostly legal edges between opposite sides
	function automatic req_t random_req();
		req_t r;
		int k;
		int f;
		int t;
		r = req_t'($bits(req_t)'($urandom));
		k = $urandom_range(0, 99);
		if (nverts > 1 && k < 85) begin
			f = $urandom_range(0, nverts - 1);
			t = $urandom_range(0, nverts - 1);
			for (int n = 0; n < 8 && sides[f] == sides[t]; n++)
				t = $urandom_range(0, nverts - 1);
			r.from_index = IDX_W'(f);
			r.to_index = IDX_W'(t);
			r.func = (k < 50) ? FUNC_INSERT : (k < 70) ? FUNC_DELETE : FUNC_CHECK;
			if ($urandom_range(0, 19) == 0)
				r.edge_length = 0;
		end else if (k < 92 && nverts < NV) begin
			r.func = FUNC_ADD;
		end
		return r;
	endfunction

	task automatic send(req_t r);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		last_pred = apply_op(r);
		pending_rsp.push_back(last_pred);
		pending_chk.push_back(func_t'(r.func) == FUNC_CHECK);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// result side: random stall bursts
	initial begin
		int burst;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (burst > 0) begin
				burst--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 13) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rsp_t exp_rsp;
		bit   is_chk;
		if (out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected transfer %p", $time, out_data);
				errors++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				is_chk = pending_chk.pop_front();
				checked++;
				if (exp_rsp.acyclic && out_data.acyclic) acyc_seen++;
				if (is_chk && !exp_rsp.acyclic && out_data.acyclic === 1'b0)
					cyc_seen++;
				if (out_data.status !== exp_rsp.status)
					$display("%0t: status expected %0d actual %0d", $time,
						exp_rsp.status, out_data.status);
				if (out_data.new_vertex_index !== exp_rsp.new_vertex_index)
					$display("%0t: new_vertex_index expected %0d actual %0d", $time,
						exp_rsp.new_vertex_index, out_data.new_vertex_index);
				if (out_data.acyclic !== exp_rsp.acyclic)
					$display("%0t: acyclic expected %0d actual %0d", $time,
						exp_rsp.acyclic, out_data.acyclic);
				if (out_data.total_edges !== exp_rsp.total_edges)
					$display("%0t: total_edges expected %0d actual %0d", $time,
						exp_rsp.total_edges, out_data.total_edges);
				if (out_data.total_vertices !== exp_rsp.total_vertices)
					$display("%0t: total_vertices expected %0d actual %0d", $time,
						exp_rsp.total_vertices, out_data.total_vertices);
				if (out_data !== exp_rsp)
					errors++;
			end
		end
	end

	// watchdog, includes the clearing pass after reset
	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		row_t rows [$];
		rsp_t got;
		int n;
		for (int i = 0; i < NV; i++) begin
			for (int j = 0; j < NV; j++)
				lengths[i][j] = '0;
			indeg[i] = 0;
			outdeg[i] = 0;
		end
		nverts = 0;
		nedges = 0;

		rows.push_back('{make_req(FUNC_CHECK, 1, 31, 31, 16'hffff), 1, '{ST_OK, 0, 1, 0, 0}});
		rows.push_back('{make_req(FUNC_INSERT, 0, 0, 0, 1), 1, '{ST_RANGE, 0, 0, 0, 0}});
		rows.push_back('{make_req(FUNC_DELETE, 0, 31, 0, 0), 1, '{ST_RANGE, 0, 0, 0, 0}});
		rows.push_back('{make_req(FUNC_ADD, 0, 31, 31, 16'hffff), 1, '{ST_OK, 0, 0, 0, 1}});
		rows.push_back('{make_req(FUNC_ADD, 1, 0, 0, 0), 1, '{ST_OK, 1, 0, 0, 2}});
		rows.push_back('{make_req(FUNC_ADD, 0, 0, 0, 0), 1, '{ST_OK, 2, 0, 0, 3}});
		rows.push_back('{make_req(FUNC_INSERT, 0, 0, 2, 5), 1, '{ST_SAME_SIDE, 0, 0, 0, 3}});
		rows.push_back('{make_req(FUNC_INSERT, 0, 0, 1, 0), 1, '{ST_ZERO_LEN, 0, 0, 0, 3}});
		rows.push_back('{make_req(FUNC_INSERT, 1, 0, 1, 16'hffff), 1, '{ST_OK, 0, 0, 1, 3}});
		rows.push_back('{make_req(FUNC_INSERT, 0, 0, 1, 7), 1, '{ST_EXISTS, 0, 0, 1, 3}});
		rows.push_back('{make_req(FUNC_INSERT, 0, 0, 3, 7), 1, '{ST_RANGE, 0, 0, 1, 3}});
		rows.push_back('{make_req(FUNC_CHECK, 0, 0, 0, 0), 1, '{ST_OK, 0, 1, 1, 3}});
		rows.push_back('{make_req(FUNC_INSERT, 0, 1, 2, 16'h8001), 0, '0});
		rows.push_back('{make_req(FUNC_INSERT, 0, 2, 1, 1), 0, '0});
		rows.push_back('{make_req(FUNC_CHECK, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_req(FUNC_DELETE, 0, 2, 1, 0), 0, '0});
		rows.push_back('{make_req(FUNC_CHECK, 1, 21, 10, 16'h5555), 0, '0});
		rows.push_back('{make_req(FUNC_DELETE, 0, 1, 0, 0), 1, '{ST_NO_EDGE, 0, 0, 2, 3}});
		rows.push_back('{make_req(FUNC_DELETE, 0, 0, 1, 0), 0, '0});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send(rows[i].req);
			got = last_pred;
			if (rows[i].has_rsp && got !== rows[i].rsp) begin
				$display("%0t: table row %0d expected %p predicted %p", $time, i,
					rows[i].rsp, got);
				errors++;
			end
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1;
			// fill to full once to reach the full status and top indices
			if (i > 150 && i < 190)
				send(make_req(FUNC_ADD, $urandom_range(0, 1), 0, 0, 0));
			else
				send(random_req());
		end
		in_valid <= 1'b0;

		n = 0;
		while (pending_rsp.size() != 0 && n < STALL_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (1200) @(posedge clk);
		$display("covered %0d results: %0d acyclic and %0d cyclic checks, graph at %0d vertices",
			checked, acyc_seen, cyc_seen, nverts);
		$display("with %0d edges after directed table and random add/insert/delete/check mix",
			nedges);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/bgcc_pkg.sv
rtl/core/bgcc_edge_mem.sv
rtl/core/bgcc_vertex_mem.sv
rtl/core/bipartite_graph_cycle_check.sv
rtl/core/bgcc_checker.sv
sim/testbench.sv
